FILE: sv/mtm_pkg.sv
// Shared types, constants and mapping functions for the MUS to MIDI translator.
package mtm_pkg;

  localparam int unsigned CHAN_CNT = 16;
  localparam int unsigned CHAN_W   = 4;

  localparam logic [7:0] ST_NOTE  = 8'h90;
  localparam logic [7:0] ST_CTRL  = 8'hB0;
  localparam logic [7:0] ST_PROG  = 8'hC0;
  localparam logic [7:0] ST_BEND  = 8'hE0;

  localparam logic [7:0] VEL_RESET    = 8'd100;
  localparam logic [7:0] VOLUME_CTRL  = 8'd7;
  localparam logic [7:0] DATA_MAX     = 8'h7F;
  localparam logic [7:0] SYS_MONO_ARG = 8'd12;

  // MUS event groups, bits 6:4 of the event byte
  localparam logic [2:0] GRP_NOTE_OFF = 3'd0;
  localparam logic [2:0] GRP_NOTE_ON  = 3'd1;
  localparam logic [2:0] GRP_BEND     = 3'd2;
  localparam logic [2:0] GRP_SYSTEM   = 3'd3;
  localparam logic [2:0] GRP_CTRL     = 3'd4;
  localparam logic [2:0] GRP_END      = 3'd6;

  typedef enum logic [1:0] {
    PH_EVENT = 2'd0,
    PH_ARG   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DELAY = 2'd3
  } phase_t;

  typedef struct packed {
    logic [31:0] delta_time;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic        is_nop;
    logic        song_end;
    logic        event_valid;
  } res_t;

  // MUS channel 15 is percussion (MIDI 9); 9..14 shift up by one
  function automatic logic [CHAN_W-1:0] map_channel(input logic [7:0] ev);
    logic [CHAN_W-1:0] c;
    c = ev[CHAN_W-1:0];
    if (c == 4'd15) begin
      return 4'd9;
    end else if (c >= 4'd9) begin
      return c + 4'd1;
    end
    return c;
  endfunction

  function automatic logic [7:0] map_ctrl(input logic [7:0] idx);
    logic [7:0] r;
    case (idx)
      8'd0:    r = 8'd0;
      8'd1:    r = 8'd0;
      8'd2:    r = 8'd1;
      8'd3:    r = 8'd7;
      8'd4:    r = 8'd10;
      8'd5:    r = 8'd11;
      8'd6:    r = 8'd91;
      8'd7:    r = 8'd93;
      8'd8:    r = 8'd64;
      8'd9:    r = 8'd67;
      8'd10:   r = 8'd120;
      8'd11:   r = 8'd123;
      8'd12:   r = 8'd126;
      8'd13:   r = 8'd127;
      8'd14:   r = 8'd121;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/mtm_out_q.sv
// Two-entry result queue that decouples the parser from the output stall.
module mtm_out_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mtm_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output mtm_pkg::res_t out_data
);

  mtm_pkg::res_t q_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          head_r, head_nxt;
  logic          tail;
  logic          pop;

  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign tail      = head_r ^ cnt_r[0];

  always_comb begin
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
    head_nxt = pop ? ~head_r : head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      head_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail] <= push_data;
    end
  end

endmodule

FILE: sv/mus_to_midi_event_translator.sv
// Top level: MUS score byte parser with per-channel velocity memory.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------
//  input    | in_score_byte, in_restart               | in_valid/in_stall
//  result   | out_delta_time .. out_event_valid       | out_valid/out_stall
//  config   | cfg_wr_data                             | cfg_wr_en
//
// One byte per cycle while in_stall is low; each result is pushed into the
// two-entry result queue as the byte that completes its event transfers.
// The velocity memory is read when the event byte transfers, so its data
// is ready for the argument byte. Synchronous reset marks every velocity
// entry as holding the default. in_stall rises only when the queue is full.
module mus_to_midi_event_translator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_score_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_delta_time,
  output logic [7:0]  out_status_byte,
  output logic [7:0]  out_data_one,
  output logic [7:0]  out_data_two,
  output logic        out_is_nop,
  output logic        out_song_end,
  output logic        out_event_valid,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data
);

  localparam int unsigned CW = mtm_pkg::CHAN_W;

  mtm_pkg::phase_t phase_r, phase_nxt, phase_eff;
  logic [7:0]      held_ev_r, held_ev_nxt;
  logic [7:0]      held_arg_r, held_arg_nxt;
  logic [31:0]     pend_r, pend_nxt, pend_eff;
  logic            ended_r, ended_nxt, ended_eff;
  logic [3:0]      num_ch_r;

  // velocity memory with per-entry valid bits
  logic [7:0]          vel_mem [mtm_pkg::CHAN_CNT];
  logic [CW-1:0]       vel_raddr, vel_waddr;
  logic                vel_rd, vel_wr;
  logic [7:0]          vel_rdata_r;
  logic                vel_rvld_r;
  logic [mtm_pkg::CHAN_CNT-1:0] vel_vld_r;
  logic [7:0]          vel_cur;

  logic          acc, work;
  logic          do_emit, do_finish, go_value, go_delay_done;
  logic [CW-1:0] ch;
  logic [2:0]    grp;
  logic [7:0]    st_byte, d_one, d_two, ctl;
  mtm_pkg::res_t res;
  mtm_pkg::res_t q_out;
  logic          q_full;

  assign acc       = in_valid && !in_stall;
  assign in_stall  = q_full;
  assign phase_eff = in_restart ? mtm_pkg::PH_EVENT : phase_r;
  assign pend_eff  = in_restart ? 32'd0 : pend_r;
  assign ended_eff = in_restart ? 1'b0 : ended_r;
  assign work      = acc && !ended_eff;
  assign ch        = mtm_pkg::map_channel(held_ev_r);
  assign grp       = held_ev_r[6:4];
  assign vel_cur   = vel_rvld_r ? vel_rdata_r : mtm_pkg::VEL_RESET;
  assign ctl       = mtm_pkg::map_ctrl(held_arg_r);

  // event decode
  always_comb begin
    do_emit       = 1'b0;
    do_finish     = 1'b0;
    go_value      = 1'b0;
    go_delay_done = 1'b0;
    st_byte       = 8'd0;
    d_one         = 8'd0;
    d_two         = 8'd0;
    vel_rd        = 1'b0;
    vel_wr        = 1'b0;
    vel_raddr     = mtm_pkg::map_channel(in_score_byte);
    vel_waddr     = ch;
    held_ev_nxt   = held_ev_r;
    held_arg_nxt  = held_arg_r;
    pend_nxt      = pend_eff;
    if (work) begin
      case (phase_eff)
        mtm_pkg::PH_EVENT: begin
          held_ev_nxt = in_score_byte;
          vel_rd      = 1'b1;
          do_finish   = (in_score_byte[6:4] == mtm_pkg::GRP_END);
        end
        mtm_pkg::PH_ARG: begin
          held_arg_nxt = in_score_byte;
          case (grp)
            mtm_pkg::GRP_NOTE_OFF: begin
              do_emit = 1'b1;
              st_byte = mtm_pkg::ST_NOTE | {4'd0, ch};
              d_one   = in_score_byte;
            end
            mtm_pkg::GRP_NOTE_ON: begin
              if (in_score_byte[7]) begin
                go_value = 1'b1;
              end else begin
                do_emit = 1'b1;
                st_byte = mtm_pkg::ST_NOTE | {4'd0, ch};
                d_one   = {1'b0, in_score_byte[6:0]};
                d_two   = vel_cur;
              end
            end
            mtm_pkg::GRP_BEND: begin
              do_emit = 1'b1;
              st_byte = mtm_pkg::ST_BEND | {4'd0, ch};
              d_one   = {1'b0, in_score_byte[0], 6'd0};
              d_two   = {1'b0, in_score_byte[7:1]};
            end
            mtm_pkg::GRP_SYSTEM: begin
              do_emit = 1'b1;
              st_byte = mtm_pkg::ST_CTRL | {4'd0, ch};
              d_one   = mtm_pkg::map_ctrl(in_score_byte);
              d_two   = (in_score_byte == mtm_pkg::SYS_MONO_ARG) ? {4'd0, num_ch_r} : 8'd0;
            end
            mtm_pkg::GRP_CTRL: begin
              go_value = 1'b1;
            end
            default: begin
              do_finish = 1'b1;
            end
          endcase
        end
        mtm_pkg::PH_VALUE: begin
          do_emit = 1'b1;
          if (grp == mtm_pkg::GRP_NOTE_ON) begin
            vel_wr  = 1'b1;
            st_byte = mtm_pkg::ST_NOTE | {4'd0, ch};
            d_one   = {1'b0, held_arg_r[6:0]};
            d_two   = in_score_byte;
          end else if (held_arg_r == 8'd0) begin
            st_byte = mtm_pkg::ST_PROG | {4'd0, ch};
            d_one   = in_score_byte;
          end else begin
            st_byte = mtm_pkg::ST_CTRL | {4'd0, ch};
            d_one   = ctl;
            d_two   = (ctl == mtm_pkg::VOLUME_CTRL && in_score_byte > mtm_pkg::DATA_MAX) ?
                      mtm_pkg::DATA_MAX : in_score_byte;
          end
        end
        mtm_pkg::PH_DELAY: begin
          pend_nxt      = {pend_eff[24:0], in_score_byte[6:0]};
          go_delay_done = !in_score_byte[7];
        end
        default: begin
          do_finish = 1'b0;
        end
      endcase
      if (do_emit || do_finish) begin
        pend_nxt = 32'd0;
      end
    end
  end

  // parse phase and end flag
  always_comb begin
    phase_nxt = phase_r;
    ended_nxt = ended_r;
    if (acc) begin
      phase_nxt = phase_eff;
      ended_nxt = ended_eff;
      if (work) begin
        if (do_finish) begin
          phase_nxt = mtm_pkg::PH_EVENT;
          ended_nxt = 1'b1;
        end else if (do_emit) begin
          phase_nxt = held_ev_r[7] ? mtm_pkg::PH_DELAY : mtm_pkg::PH_EVENT;
        end else if (go_value) begin
          phase_nxt = mtm_pkg::PH_VALUE;
        end else if (phase_eff == mtm_pkg::PH_EVENT) begin
          phase_nxt = mtm_pkg::PH_ARG;
        end else if (go_delay_done) begin
          phase_nxt = mtm_pkg::PH_EVENT;
        end
      end
    end
  end

  // result payload
  always_comb begin
    res.delta_time  = pend_eff;
    res.status_byte = st_byte;
    res.data_one    = d_one;
    res.data_two    = d_two;
    res.is_nop      = do_finish && (pend_eff != 32'd0);
    res.song_end    = do_finish;
    res.event_valid = do_emit || (pend_eff != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mtm_pkg::PH_EVENT;
      held_ev_r  <= 8'd0;
      held_arg_r <= 8'd0;
      pend_r     <= 32'd0;
      ended_r    <= 1'b0;
      num_ch_r   <= 4'd0;
      vel_vld_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      held_ev_r  <= held_ev_nxt;
      held_arg_r <= held_arg_nxt;
      pend_r     <= acc ? pend_nxt : pend_r;
      ended_r    <= ended_nxt;
      if (cfg_wr_en) begin
        num_ch_r <= cfg_wr_data;
      end
      if (vel_wr) begin
        vel_vld_r[vel_waddr] <= 1'b1;
      end
    end
  end

  // velocity memory: write in the value phase, read at the event byte
  always_ff @(posedge clk) begin
    if (vel_wr) begin
      vel_mem[vel_waddr] <= in_score_byte;
    end
    if (vel_rd) begin
      vel_rdata_r <= vel_mem[vel_raddr];
      vel_rvld_r  <= vel_vld_r[vel_raddr];
    end
  end

  mtm_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (do_emit || do_finish),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_out)
  );

  assign out_delta_time  = q_out.delta_time;
  assign out_status_byte = q_out.status_byte;
  assign out_data_one    = q_out.data_one;
  assign out_data_two    = q_out.data_two;
  assign out_is_nop      = q_out.is_nop;
  assign out_song_end    = q_out.song_end;
  assign out_event_valid = q_out.event_valid;

endmodule
